FILE: rtl/cth_pkg.sv
// ----------------------------------------------------------------------------
// cth_pkg
// Shared types and constants for the color tolerance histogram.
// ----------------------------------------------------------------------------
`default_nettype none

package cth_pkg;

  localparam int Capacity = 32;
  localparam int IdxW     = $clog2(Capacity);
  localparam int CntW     = $clog2(Capacity + 1);

  localparam int ChanW    = 8;
  localparam int ColorW   = 3 * ChanW;
  localparam int TotalW   = 32;
  localparam int RunW     = 8;
  localparam int SlotW    = 5;

  localparam int InDataW  = 40;  // red, green, blue, run_count, read_slot + pad
  localparam int OutDataW = 72;  // slot, rgb, total, used + pad

  typedef enum logic [0:0] {
    FUNC_INSERT = 1'b0,
    FUNC_READ   = 1'b1
  } func_e;

  typedef enum logic [1:0] {
    STATUS_MATCH    = 2'd0,
    STATUS_INSERTED = 2'd1,
    STATUS_FULL     = 2'd2,
    STATUS_EMPTY    = 2'd3
  } status_e;

  typedef struct packed {
    logic [SlotW-1:0]  slot;
    logic [ChanW-1:0]  red;
    logic [ChanW-1:0]  green;
    logic [ChanW-1:0]  blue;
    logic [TotalW-1:0] total;
    status_e           status;
    logic [CntW-1:0]   used;
  } result_t;

endpackage

`default_nettype wire

FILE: rtl/cth_match.sv
// ----------------------------------------------------------------------------
// cth_match
// Tolerance compare unit: stored color against incoming color, per channel.
// ----------------------------------------------------------------------------
`default_nettype none

module cth_match (
  input  wire logic [cth_pkg::ColorW-1:0] stored_i,
  input  wire logic [cth_pkg::ChanW-1:0]  red_i,
  input  wire logic [cth_pkg::ChanW-1:0]  green_i,
  input  wire logic [cth_pkg::ChanW-1:0]  blue_i,
  input  wire logic [cth_pkg::ChanW-1:0]  bound_i,
  output logic                            hit_o
);
  import cth_pkg::*;

  logic [ChanW-1:0] inc [3];
  logic [ChanW-1:0] sto [3];
  logic [2:0]       close;

  assign inc[0] = red_i;
  assign inc[1] = green_i;
  assign inc[2] = blue_i;
  assign sto[0] = stored_i[3*ChanW-1:2*ChanW];
  assign sto[1] = stored_i[2*ChanW-1:ChanW];
  assign sto[2] = stored_i[ChanW-1:0];

  // absolute difference per channel, then bound compare
  always_comb begin
    for (int c = 0; c < 3; c++) begin
      if (sto[c] > inc[c]) begin
        close[c] = (sto[c] - inc[c]) <= bound_i;
      end else begin
        close[c] = (inc[c] - sto[c]) <= bound_i;
      end
    end
  end

  assign hit_o = &close;

endmodule

`default_nettype wire

FILE: rtl/color_tolerance_histogram.sv
// ----------------------------------------------------------------------------
// color_tolerance_histogram
// Palette histogram of RGB colors with a per-channel match tolerance.
// ----------------------------------------------------------------------------
// Usage:
//   s_axis carries one item per operation. tuser selects insert (0) or read
//   (1). An insert walks the used entries in order, one entry per cycle
//   through a single compare unit fed by the entry memory's registered read
//   port. The first entry within +/- match_bound on all three channels gets
//   run_count added (saturating); with no match the color is appended; with
//   a full table it is dropped and flagged. A read returns one entry.
//   m_axis returns exactly one result item per accepted item.
//   Steps: an insert that matches goes SEARCH, UPD, DONE; a miss goes SEARCH
//   over all used entries, INS, DONE (INS alone on an empty table); a read
//   goes RDOUT, DONE, or straight to DONE when the slot is unused. One item
//   is in flight at a time: no new item is accepted until the last is done.
//   The output register frees the core: a new item is accepted while the last
//   result still waits, and a finished result is held in the core until the
//   output register drains, so a stalled receiver simply backs up the input.
//   Reset empties the table (used count to zero) and clears match_bound; the
//   entry memory itself is not cleared, only used entries are ever read.
//   cfg writes (match_bound) are always accepted; write only while idle.
// ----------------------------------------------------------------------------
`default_nettype none

module color_tolerance_histogram (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  // configuration: match_bound
  input  wire logic                          cfg_valid_i,
  output logic                               cfg_ready_o,
  input  wire logic [cth_pkg::ChanW-1:0]     cfg_data_i,
  // input items
  input  wire logic                          s_axis_tvalid,
  output logic                               s_axis_tready,
  // tdata: red_in[7:0], green_in[15:8], blue_in[23:16], run_count[31:24],
  //        read_slot[36:32], zero pad[39:37]
  input  wire logic [cth_pkg::InDataW-1:0]   s_axis_tdata,
  // tuser: func[0]
  input  wire logic                          s_axis_tuser,
  // result items
  output logic                               m_axis_tvalid,
  input  wire logic                          m_axis_tready,
  // tdata: slot[4:0], red_out[12:5], green_out[20:13], blue_out[28:21],
  //        total[60:29], used[66:61], zero pad[71:67]
  output logic [cth_pkg::OutDataW-1:0]       m_axis_tdata,
  // tuser: status[1:0]
  output logic [1:0]                         m_axis_tuser
);
  import cth_pkg::*;

  // sequencer states
  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_SEARCH = 3'd1;  // compare entry idx_q, fetch next
  localparam logic [2:0] S_UPD    = 3'd2;  // add run to matched entry
  localparam logic [2:0] S_INS    = 3'd3;  // append or drop
  localparam logic [2:0] S_RDOUT  = 3'd4;  // read data valid
  localparam logic [2:0] S_DONE   = 3'd5;  // hand result to output register

  logic [2:0]        state_q, state_d;
  logic [ChanW-1:0]  bound_q;
  logic [CntW-1:0]   used_q, used_d;
  logic [IdxW-1:0]   idx_q, idx_d;
  logic [ChanW-1:0]  red_q, green_q, blue_q;
  logic [RunW-1:0]   run_q;
  result_t           res_q, res_d;
  result_t           out_q;
  logic              out_valid_q;

  // input unpacking
  logic [ChanW-1:0]  in_red, in_green, in_blue;
  logic [RunW-1:0]   in_run;
  logic [SlotW-1:0]  in_slot;
  logic              accept;

  assign in_red   = s_axis_tdata[7:0];
  assign in_green = s_axis_tdata[15:8];
  assign in_blue  = s_axis_tdata[23:16];
  assign in_run   = s_axis_tdata[31:24];
  assign in_slot  = s_axis_tdata[36:32];

  assign s_axis_tready = (state_q == S_IDLE);
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign cfg_ready_o   = 1'b1;

  // ---------------------------------------------------------------- memory
  logic [ColorW-1:0] color_mem [Capacity];
  logic [TotalW-1:0] total_mem [Capacity];
  logic [ColorW-1:0] rd_color_q;
  logic [TotalW-1:0] rd_total_q;
  logic              rd_en;
  logic [IdxW-1:0]   rd_addr;
  logic              wr_total_en, wr_color_en;
  logic [IdxW-1:0]   wr_addr;
  logic [TotalW-1:0] wr_total;

  always_ff @(posedge clk_i) begin
    if (wr_color_en) begin
      color_mem[wr_addr] <= {red_q, green_q, blue_q};
    end
    if (wr_total_en) begin
      total_mem[wr_addr] <= wr_total;
    end
    if (rd_en) begin
      rd_color_q <= color_mem[rd_addr];
      rd_total_q <= total_mem[rd_addr];
    end
  end

  // ---------------------------------------------------------- compare unit
  logic hit;

  cth_match u_match (
    .stored_i (rd_color_q),
    .red_i    (red_q),
    .green_i  (green_q),
    .blue_i   (blue_q),
    .bound_i  (bound_q),
    .hit_o    (hit)
  );

  // saturating add of the run onto the fetched count
  logic [TotalW:0]   sum;
  logic [TotalW-1:0] sat_total;

  assign sum       = {1'b0, rd_total_q} + {{(TotalW + 1 - RunW){1'b0}}, run_q};
  assign sat_total = sum[TotalW] ? {TotalW{1'b1}} : sum[TotalW-1:0];

  logic             last_entry;
  logic             full;
  logic [CntW-1:0]  idx_ext;

  assign idx_ext    = {{(CntW - IdxW){1'b0}}, idx_q};
  assign last_entry = (idx_ext + 1'b1) == used_q;
  assign full       = used_q == CntW'(Capacity);

  // ------------------------------------------------------------- sequencer
  always_comb begin
    state_d     = state_q;
    idx_d       = idx_q;
    used_d      = used_q;
    res_d       = res_q;
    rd_en       = 1'b0;
    rd_addr     = idx_q + 1'b1;
    wr_color_en = 1'b0;
    wr_total_en = 1'b0;
    wr_addr     = idx_q;
    wr_total    = sat_total;

    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          if (s_axis_tuser == FUNC_READ) begin
            idx_d   = in_slot;
            rd_addr = in_slot;
            if ({{(CntW - SlotW){1'b0}}, in_slot} < used_q) begin
              rd_en   = 1'b1;
              state_d = S_RDOUT;
            end else begin
              res_d        = '0;
              res_d.status = STATUS_EMPTY;
              res_d.used   = used_q;
              state_d      = S_DONE;
            end
          end else if (used_q == '0) begin
            state_d = S_INS;
          end else begin
            idx_d   = '0;
            rd_addr = '0;
            rd_en   = 1'b1;
            state_d = S_SEARCH;
          end
        end
      end
      S_SEARCH: begin
        if (hit) begin
          state_d = S_UPD;
        end else if (last_entry) begin
          state_d = S_INS;
        end else begin
          rd_en   = 1'b1;
          idx_d   = idx_q + 1'b1;
        end
      end
      S_UPD: begin
        wr_total_en  = 1'b1;
        res_d.slot   = idx_q;
        res_d.red    = rd_color_q[3*ChanW-1:2*ChanW];
        res_d.green  = rd_color_q[2*ChanW-1:ChanW];
        res_d.blue   = rd_color_q[ChanW-1:0];
        res_d.total  = sat_total;
        res_d.status = STATUS_MATCH;
        res_d.used   = used_q;
        state_d      = S_DONE;
      end
      S_INS: begin
        if (full) begin
          res_d        = '0;
          res_d.status = STATUS_FULL;
          res_d.used   = used_q;
        end else begin
          wr_addr      = used_q[IdxW-1:0];
          wr_color_en  = 1'b1;
          wr_total_en  = 1'b1;
          wr_total     = {{(TotalW - RunW){1'b0}}, run_q};
          used_d       = used_q + 1'b1;
          res_d.slot   = used_q[IdxW-1:0];
          res_d.red    = red_q;
          res_d.green  = green_q;
          res_d.blue   = blue_q;
          res_d.total  = {{(TotalW - RunW){1'b0}}, run_q};
          res_d.status = STATUS_INSERTED;
          res_d.used   = used_q + 1'b1;
        end
        state_d = S_DONE;
      end
      S_RDOUT: begin
        res_d.slot   = idx_q;
        res_d.red    = rd_color_q[3*ChanW-1:2*ChanW];
        res_d.green  = rd_color_q[2*ChanW-1:ChanW];
        res_d.blue   = rd_color_q[ChanW-1:0];
        res_d.total  = rd_total_q;
        res_d.status = STATUS_MATCH;
        res_d.used   = used_q;
        state_d      = S_DONE;
      end
      S_DONE: begin
        if (!out_valid_q || m_axis_tready) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      used_q      <= '0;
      bound_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      used_q  <= used_d;
      if (cfg_valid_i && cfg_ready_o) begin
        bound_q <= cfg_data_i;
      end
      if (state_q == S_DONE && (!out_valid_q || m_axis_tready)) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    idx_q <= idx_d;
    res_q <= res_d;
    if (accept) begin
      red_q   <= in_red;
      green_q <= in_green;
      blue_q  <= in_blue;
      run_q   <= in_run;
    end
    if (state_q == S_DONE && (!out_valid_q || m_axis_tready)) begin
      out_q <= res_q;
    end
  end

  // ---------------------------------------------------------------- output
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tuser  = out_q.status;
  assign m_axis_tdata  = {5'b0, out_q.used, out_q.total, out_q.blue,
                          out_q.green, out_q.red, out_q.slot};

  // ------------------------------------------------------------ assertions
  a_used_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    used_q <= CntW'(Capacity))
    else $error("used count above capacity");

  a_search_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_SEARCH |-> idx_ext < used_q)
    else $error("search index beyond used entries");

  a_insert_grows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_INS && !full) |=> used_q == $past(used_q) + 1'b1)
    else $error("append did not grow used count");

  a_ready_idle_only: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> state_q != S_IDLE)
    else $error("sequencer stayed idle after accepting an item");

endmodule

`default_nettype wire

FILE: test/tb_color_tolerance_histogram.sv
// ----------------------------------------------------------------------------
// tb_color_tolerance_histogram
// Self-checking bench for the palette histogram: a short table of directed
// items with hand-worked results, then about 900 random items checked against
// a behavioral palette kept in the bench. The match bound is changed only
// while the block is drained. Both stream sides idle at random in three
// patterns, the receiver is held off once for a long stretch, and the sender
// pauses once until every owed result has come back.
// ----------------------------------------------------------------------------
module tb_color_tolerance_histogram;
  import cth_pkg::*;

  localparam int NumDirRows   = 21;
  localparam int ItemsPerPass = 300;
  localparam int HoldCycles   = 400;   // long receiver hold-off
  localparam int QuietLimit   = 5000;  // cycles with no handshake at all

  typedef enum logic {
    ROW_ITEM,
    ROW_CFG
  } row_kind_e;

  // one result item, unpacked from m_axis
  typedef struct packed {
    logic [4:0]  slot;
    logic [7:0]  red;
    logic [7:0]  green;
    logic [7:0]  blue;
    logic [31:0] total;
    status_e     status;
    logic [5:0]  used;
  } palette_result_t;

  // one directed row; bound is used by ROW_CFG only
  typedef struct packed {
    row_kind_e       kind;
    func_e           func;
    logic [7:0]      red;
    logic [7:0]      green;
    logic [7:0]      blue;
    logic [7:0]      run;
    logic [4:0]      rsel;
    logic [7:0]      bound;
    logic            typed;
    palette_result_t want;
  } stim_row_t;

  logic                 clk_i         = 1'b0;
  logic                 rst_ni        = 1'b0;
  logic                 cfg_valid_i   = 1'b0;
  logic                 cfg_ready_o;
  logic [ChanW-1:0]     cfg_data_i    = '0;
  logic                 s_axis_tvalid = 1'b0;
  logic                 s_axis_tready;
  logic [InDataW-1:0]   s_axis_tdata  = '0;
  logic                 s_axis_tuser  = 1'b0;
  logic                 m_axis_tvalid;
  logic                 m_axis_tready = 1'b0;
  logic [OutDataW-1:0]  m_axis_tdata;
  logic [1:0]           m_axis_tuser;

  // behavioral palette: colors as {red, green, blue}
  logic [23:0]          pal_color [Capacity];
  logic [31:0]          pal_count [Capacity];
  int                   pal_used;
  logic [7:0]           bound_q;

  palette_result_t      owed_q [$];    // results still to come, oldest first
  int                   mismatches;
  int                   send_idle_pct;
  int                   rcv_idle_pct;
  int                   hold_req;      // bumped by the sender to ask for a hold-off
  stim_row_t            dir_rows [NumDirRows];

  color_tolerance_histogram i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  initial begin
    forever begin
      #2 clk_i = ~clk_i;
    end
  end

  // --------------------------------------------------------------------------
  // Palette predictor
  // --------------------------------------------------------------------------
  function automatic bit chan_near(logic [7:0] stored, logic [7:0] incoming);
    int diff;
    diff = (stored > incoming) ? int'(stored) - int'(incoming)
                               : int'(incoming) - int'(stored);
    return diff <= int'(bound_q);
  endfunction

  // Applies one accepted item to the palette and returns its result.
  function automatic palette_result_t histogram_step(func_e f, logic [7:0] r,
                                                     logic [7:0] g, logic [7:0] b,
                                                     logic [7:0] run,
                                                     logic [4:0] rs);
    palette_result_t res;
    logic [32:0]     sum;
    res = '0;
    if (f == FUNC_READ) begin
      if (int'(rs) < pal_used) begin
        res.slot = rs;
        {res.red, res.green, res.blue} = pal_color[rs];
        res.total  = pal_count[rs];
        res.status = STATUS_MATCH;
      end else begin
        res.status = STATUS_EMPTY;
      end
      res.used = 6'(pal_used);
      return res;
    end
    // first entry within the bound on all channels wins
    for (int i = 0; i < pal_used; i++) begin
      if (chan_near(pal_color[i][23:16], r) && chan_near(pal_color[i][15:8], g) &&
          chan_near(pal_color[i][7:0], b)) begin
        sum = {1'b0, pal_count[i]} + {25'd0, run};
        pal_count[i] = sum[32] ? 32'hFFFF_FFFF : sum[31:0];
        res.slot = 5'(i);
        {res.red, res.green, res.blue} = pal_color[i];
        res.total  = pal_count[i];
        res.status = STATUS_MATCH;
        res.used   = 6'(pal_used);
        return res;
      end
    end
    if (pal_used < Capacity) begin
      pal_color[pal_used] = {r, g, b};
      pal_count[pal_used] = {24'd0, run};
      res.slot   = 5'(pal_used);
      res.red    = r;
      res.green  = g;
      res.blue   = b;
      res.total  = {24'd0, run};
      res.status = STATUS_INSERTED;
      pal_used++;
    end else begin
      res.status = STATUS_FULL;  // dropped, palette unchanged
    end
    res.used = 6'(pal_used);
    return res;
  endfunction

  // --------------------------------------------------------------------------
  // Sender side
  // --------------------------------------------------------------------------
  // Offers one item after a random idle gap; returns once it is taken.
  task automatic send_item(func_e f, logic [7:0] r, logic [7:0] g, logic [7:0] b,
                           logic [7:0] run, logic [4:0] rs, logic typed,
                           palette_result_t want);
    palette_result_t res;
    while ($urandom_range(0, 99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {3'd0, rs, run, b, g, r};
    s_axis_tuser  <= f;
    @(posedge clk_i);
    while (!s_axis_tready) begin
      @(posedge clk_i);
    end
    res = histogram_step(f, r, g, b, run, rs);
    owed_q.push_back(typed ? want : res);
  endtask

  task automatic wait_drained();
    while (owed_q.size() != 0) begin
      @(posedge clk_i);
    end
    repeat (4) @(posedge clk_i);  // let the core settle before touching config
  endtask

  task automatic write_bound(logic [7:0] value);
    s_axis_tvalid <= 1'b0;
    wait_drained();
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= value;
    @(posedge clk_i);
    while (!cfg_ready_o) begin
      @(posedge clk_i);
    end
    cfg_valid_i <= 1'b0;
    bound_q = value;
  endtask

  // --------------------------------------------------------------------------
  // Receiver side: checks each result item, then picks next cycle's tready
  // --------------------------------------------------------------------------
  task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %0d actual %0d", $time, name, want, got);
      mismatches++;
    end
  endtask

  initial begin
    palette_result_t want;
    int              hold_ack;
    int              hold_left;
    hold_ack  = 0;
    hold_left = 0;
    forever begin
      @(posedge clk_i);
      if (m_axis_tvalid && m_axis_tready) begin
        if (owed_q.size() == 0) begin
          $display("%0t: result item with nothing owed, expected none actual %h",
                   $time, m_axis_tdata);
          mismatches++;
        end else begin
          want = owed_q.pop_front();
          check_field("slot",   32'(want.slot),   32'(m_axis_tdata[4:0]));
          check_field("red",    32'(want.red),    32'(m_axis_tdata[12:5]));
          check_field("green",  32'(want.green),  32'(m_axis_tdata[20:13]));
          check_field("blue",   32'(want.blue),   32'(m_axis_tdata[28:21]));
          check_field("total",  want.total,       m_axis_tdata[60:29]);
          check_field("status", 32'(want.status), 32'(m_axis_tuser));
          check_field("used",   32'(want.used),   32'(m_axis_tdata[66:61]));
        end
      end
      if (hold_req != hold_ack) begin
        hold_ack  = hold_req;
        hold_left = HoldCycles;
      end
      if (hold_left > 0) begin
        hold_left--;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= ($urandom_range(0, 99) >= rcv_idle_pct);
      end
    end
  end

  // watchdog: a long stretch with no handshake on any channel is a hang
  initial begin
    int quiet;
    quiet = 0;
    forever begin
      @(posedge clk_i);
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
          (cfg_valid_i && cfg_ready_o)) begin
        quiet = 0;
      end else begin
        quiet++;
      end
      if (quiet >= QuietLimit) begin
        $display("FAIL");
        $finish;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus
  // --------------------------------------------------------------------------
  initial begin
    func_e       f;
    logic [7:0]  r, g, b, run;
    logic [4:0]  rs;
    logic [23:0] base;
    int          pick, span, chan;
    logic [7:0]  pass_bound [3];

    mismatches    = 0;
    hold_req      = 0;
    pal_used      = 0;
    bound_q       = '0;
    send_idle_pct = 10;
    rcv_idle_pct  = 71;
    pass_bound    = '{8'd10, 8'd255, 8'd0};

    // Hand-worked rows; the first touches an empty palette, then exact
    // matches, a zero run count, insertion order, the first-match rule under
    // a bound of 1, and a bound of 255 that pulls everything onto entry 0.
    // A full palette is reached in the random part.
    dir_rows = '{
      '{ROW_ITEM, FUNC_READ,   8'd0,   8'd0,   8'd0,   8'd0,   5'd0,  8'd0,   1'b1,
        '{5'd0, 8'd0,   8'd0,   8'd0,   32'd0,   STATUS_EMPTY,    6'd0}},
      '{ROW_ITEM, FUNC_INSERT, 8'd0,   8'd0,   8'd0,   8'd1,   5'd0,  8'd0,   1'b1,
        '{5'd0, 8'd0,   8'd0,   8'd0,   32'd1,   STATUS_INSERTED, 6'd1}},
      '{ROW_ITEM, FUNC_INSERT, 8'd0,   8'd0,   8'd0,   8'd128, 5'd0,  8'd0,   1'b1,
        '{5'd0, 8'd0,   8'd0,   8'd0,   32'd129, STATUS_MATCH,    6'd1}},
      // run count of zero inserts, then matches adding nothing
      '{ROW_ITEM, FUNC_INSERT, 8'd255, 8'd255, 8'd255, 8'd0,   5'd31, 8'd0,   1'b1,
        '{5'd1, 8'd255, 8'd255, 8'd255, 32'd0,   STATUS_INSERTED, 6'd2}},
      '{ROW_ITEM, FUNC_INSERT, 8'd255, 8'd255, 8'd255, 8'd0,   5'd31, 8'd0,   1'b1,
        '{5'd1, 8'd255, 8'd255, 8'd255, 32'd0,   STATUS_MATCH,    6'd2}},
      '{ROW_ITEM, FUNC_INSERT, 8'd1,   8'd0,   8'd0,   8'd255, 5'd0,  8'd0,   1'b1,
        '{5'd2, 8'd1,   8'd0,   8'd0,   32'd255, STATUS_INSERTED, 6'd3}},
      '{ROW_ITEM, FUNC_READ,   8'd0,   8'd0,   8'd0,   8'd0,   5'd1,  8'd0,   1'b1,
        '{5'd1, 8'd255, 8'd255, 8'd255, 32'd0,   STATUS_MATCH,    6'd3}},
      '{ROW_ITEM, FUNC_READ,   8'd0,   8'd0,   8'd0,   8'd0,   5'd3,  8'd0,   1'b1,
        '{5'd0, 8'd0,   8'd0,   8'd0,   32'd0,   STATUS_EMPTY,    6'd3}},
      '{ROW_ITEM, FUNC_READ,   8'd255, 8'd255, 8'd255, 8'd255, 5'd31, 8'd0,   1'b1,
        '{5'd0, 8'd0,   8'd0,   8'd0,   32'd0,   STATUS_EMPTY,    6'd3}},
      '{ROW_CFG,  FUNC_INSERT, 8'd0,   8'd0,   8'd0,   8'd0,   5'd0,  8'd1,   1'b0, '0},
      '{ROW_ITEM, FUNC_INSERT, 8'd1,   8'd1,   8'd1,   8'd7,   5'd0,  8'd0,   1'b1,
        '{5'd0, 8'd0,   8'd0,   8'd0,   32'd136, STATUS_MATCH,    6'd3}},
      '{ROW_ITEM, FUNC_INSERT, 8'd254, 8'd254, 8'd254, 8'd2,   5'd0,  8'd0,   1'b1,
        '{5'd1, 8'd255, 8'd255, 8'd255, 32'd2,   STATUS_MATCH,    6'd3}},
      '{ROW_ITEM, FUNC_INSERT, 8'd0,   8'd2,   8'd0,   8'd1,   5'd0,  8'd0,   1'b1,
        '{5'd3, 8'd0,   8'd2,   8'd0,   32'd1,   STATUS_INSERTED, 6'd4}},
      '{ROW_ITEM, FUNC_INSERT, 8'd2,   8'd0,   8'd0,   8'd3,   5'd0,  8'd0,   1'b1,
        '{5'd2, 8'd1,   8'd0,   8'd0,   32'd258, STATUS_MATCH,    6'd4}},
      '{ROW_CFG,  FUNC_INSERT, 8'd0,   8'd0,   8'd0,   8'd0,   5'd0,  8'd255, 1'b0, '0},
      '{ROW_ITEM, FUNC_INSERT, 8'hAA,  8'h55,  8'h0F,  8'd128, 5'd0,  8'd0,   1'b1,
        '{5'd0, 8'd0,   8'd0,   8'd0,   32'd264, STATUS_MATCH,    6'd4}},
      '{ROW_ITEM, FUNC_READ,   8'd0,   8'd0,   8'd0,   8'd0,   5'd0,  8'd0,   1'b1,
        '{5'd0, 8'd0,   8'd0,   8'd0,   32'd264, STATUS_MATCH,    6'd4}},
      '{ROW_CFG,  FUNC_INSERT, 8'd0,   8'd0,   8'd0,   8'd0,   5'd0,  8'd0,   1'b0, '0},
      '{ROW_ITEM, FUNC_INSERT, 8'h80,  8'h40,  8'h20,  8'h5A,  5'h15, 8'd0,   1'b0, '0},
      '{ROW_ITEM, FUNC_READ,   8'h55,  8'hAA,  8'hF0,  8'hA5,  5'd4,  8'd0,   1'b0, '0},
      '{ROW_ITEM, FUNC_READ,   8'd0,   8'd0,   8'd0,   8'd0,   5'd5,  8'd0,   1'b1,
        '{5'd0, 8'd0,   8'd0,   8'd0,   32'd0,   STATUS_EMPTY,    6'd5}}
    };

    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (dir_rows[i]) begin
      if (dir_rows[i].kind == ROW_CFG) begin
        write_bound(dir_rows[i].bound);
      end else begin
        send_item(dir_rows[i].func, dir_rows[i].red, dir_rows[i].green,
                  dir_rows[i].blue, dir_rows[i].run, dir_rows[i].rsel,
                  dir_rows[i].typed, dir_rows[i].want);
      end
    end

    // Random passes: sender idles 10% / receiver 71%, then the reverse, then
    // no idling. The first pass (bound 10) fills the palette; afterwards new
    // colors are dropped as full while near copies keep matching.
    for (int pass = 0; pass < 3; pass++) begin
      write_bound(pass_bound[pass]);
      send_idle_pct = (pass == 0) ? 10 : (pass == 1) ? 71 : 0;
      rcv_idle_pct  = (pass == 0) ? 71 : (pass == 1) ? 10 : 0;
      for (int n = 0; n < ItemsPerPass; n++) begin
        if (pass == 0 && n == 40) begin
          hold_req++;         // receiver stalls, input should back up
        end
        if (pass == 1 && n == 150) begin
          s_axis_tvalid <= 1'b0;
          wait_drained();     // sender pause until nothing is owed
        end
        f    = FUNC_INSERT;
        r    = 8'($urandom_range(0, 255));
        g    = 8'($urandom_range(0, 255));
        b    = 8'($urandom_range(0, 255));
        rs   = 5'($urandom_range(0, 31));
        run  = ($urandom_range(0, 9) == 0) ? 8'($urandom_range(0, 255))
                                           : 8'($urandom_range(1, 128));
        pick = $urandom_range(0, 99);
        if (pick < 25) begin
          f = FUNC_READ;
        end else if (pick >= 40 && pal_used > 0) begin
          base = pal_color[$urandom_range(0, pal_used - 1)];
          {r, g, b} = base;
          if (pick >= 55) begin
            // near copy: each channel off by up to one past the bound
            span = int'(bound_q) + 1;
            for (int c = 0; c < 3; c++) begin
              chan = int'(base[16 - 8*c +: 8]) + int'($urandom_range(0, 2*span)) - span;
              chan = (chan < 0) ? 0 : (chan > 255) ? 255 : chan;
              if (c == 0) r = 8'(chan);
              else if (c == 1) g = 8'(chan);
              else b = 8'(chan);
            end
          end
        end
        send_item(f, r, g, b, run, rs, 1'b0, '0);
      end
    end

    s_axis_tvalid <= 1'b0;
    while (owed_q.size() != 0) begin
      @(posedge clk_i);
    end
    repeat (40) @(posedge clk_i);  // catch any stray result item

    if (mismatches == 0 && owed_q.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
